// ----- hdl/bmpt_pkg.sv -----
// ----------------------------------------------------------------------------
// bmpt_pkg
// Types and constants shared by the binomial-mod-prime table block: beat
// payloads, request and status codes, and the modulus with its Barrett factor.
// ----------------------------------------------------------------------------
`default_nettype none

package bmpt_pkg;

    // Width of a residue modulo the prime.
    localparam int MOD_W = 30;

    // The prime modulus.
    localparam logic [MOD_W-1:0] PRIME = 30'd1000000007;

    // Exponent for the Fermat inverse, P-2.
    localparam logic [MOD_W-1:0] INV_EXP = 30'd1000000005;

    // Barrett factor floor(2^60 / P), 31 bits wide.
    localparam logic [63:0] MU_FULL = 64'h1000_0000_0000_0000 / 64'd1000000007;
    localparam logic [30:0] MU      = MU_FULL[30:0];

    // Request type codes.
    localparam logic [1:0] REQ_BUILD = 2'd0;
    localparam logic [1:0] REQ_NCR   = 2'd1;
    localparam logic [1:0] REQ_NPR   = 2'd2;
    localparam logic [1:0] REQ_STARS = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_NOT_BUILT = 2'd2;

    // Configuration register index of table_top.
    localparam logic REG_TABLE_TOP = 1'b0;

    // Request beat.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [19:0] n_value;
        logic [19:0] r_value;
    } req_t;

    // Response beat.
    typedef struct packed {
        logic [29:0] result_value;
        logic [1:0]  status;
    } rsp_t;

endpackage

`default_nettype wire

// ----- hdl/bmpt_modmul.sv -----
// ----------------------------------------------------------------------------
// bmpt_modmul
// Five-stage pipelined modular multiplier: a*b mod P with Barrett reduction.
// ----------------------------------------------------------------------------
`default_nettype none

module bmpt_modmul (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      go,
    input  wire logic [bmpt_pkg::MOD_W-1:0] op_a,
    input  wire logic [bmpt_pkg::MOD_W-1:0] op_b,
    output logic                           done,
    output logic [bmpt_pkg::MOD_W-1:0]      product
);

    logic [4:0]  vld_reg;
    logic [59:0] prod_reg;
    logic [61:0] q2_reg;
    logic [31:0] x2_reg;
    logic [31:0] x3_reg;
    logic [31:0] qp_reg;
    logic [31:0] r_reg;
    logic [29:0] out_reg;
    logic [30:0] q3;
    logic [61:0] qp_full;
    logic [31:0] p32;

    assign p32     = {2'b00, bmpt_pkg::PRIME};
    assign q3      = q2_reg[61:31];
    assign qp_full = q3 * {1'b0, bmpt_pkg::PRIME};

    // Valid bits travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], go};
        end
    end

    // Datapath stages: product, quotient estimate, q*P, remainder, correction.
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        q2_reg   <= prod_reg[59:29] * bmpt_pkg::MU;
        x2_reg   <= prod_reg[31:0];
        x3_reg   <= x2_reg;
        qp_reg   <= qp_full[31:0];
        r_reg    <= x3_reg - qp_reg;
        // The remainder is below three times P here.
        if (r_reg >= {p32[30:0], 1'b0})
        begin
            out_reg <= 30'(r_reg - {p32[30:0], 1'b0});
        end
        else if (r_reg >= p32)
        begin
            out_reg <= 30'(r_reg - p32);
        end
        else
        begin
            out_reg <= r_reg[29:0];
        end
    end

    assign done    = vld_reg[4];
    assign product = out_reg;

endmodule

`default_nettype wire

// ----- hdl/binomial_mod_prime_tables.sv -----
// ----------------------------------------------------------------------------
// binomial_mod_prime_tables
// Factorial and inverse-factorial tables modulo 1000000007, answering nCr,
// nPr and stars-and-bars queries.
// ----------------------------------------------------------------------------
// One request is worked at a time. A combinations or stars-and-bars query
// makes two dependent trips through the five-stage modular multiplier after
// two memory reads, and a permutations query makes one. A query that is
// answered by its checks alone skips the tables and the multiplier. A build
// walks the factorial table upward, raises the top factorial to the power
// P-2 by square and multiply, then walks the inverse table downward, each
// step waiting on the multiplier. The tables sit in two single-port memories;
// there is no clearing pass, since no query reaches an entry the last build
// did not write. A new request may be accepted while the previous response
// beat is still waiting to be taken.
`default_nettype none

module binomial_mod_prime_tables #(
    parameter int MAX_INDEX = 65535
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire bmpt_pkg::req_t   req,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output bmpt_pkg::rsp_t        rsp,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int AW    = (MAX_INDEX < 2) ? 1 : $clog2(MAX_INDEX + 1);
    localparam int DEPTH = MAX_INDEX + 1;
    localparam int MW    = bmpt_pkg::MOD_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_Q_RD,
        S_Q_MUL1,
        S_Q_WAIT1,
        S_Q_WAIT2,
        S_B_FACT,
        S_B_FWAIT,
        S_P_BIT,
        S_P_AWAIT,
        S_P_SQ,
        S_P_SWAIT,
        S_B_INV,
        S_I_WAIT,
        S_DONE
    } state_t;

    state_t         state_reg;
    logic [15:0]    table_top_reg;
    logic           ready_reg;
    logic [15:0]    built_top_reg;
    logic [15:0]    top_reg;
    logic [15:0]    i_reg;
    logic [4:0]     bit_reg;
    logic [MW-1:0]  run_reg;
    logic [MW-1:0]  acc_reg;
    bmpt_pkg::req_t req_reg;
    logic [20:0]    nn_reg;
    logic [20:0]    rr_reg;
    logic [MW-1:0]  value_reg;
    logic [1:0]     status_reg;
    logic           out_valid_reg;
    bmpt_pkg::rsp_t out_reg;
    logic           mul_go_reg;
    logic [MW-1:0]  mul_a_reg;
    logic [MW-1:0]  mul_b_reg;

    logic           mul_done;
    logic [MW-1:0]  mul_res;
    logic [15:0]    top_clamp;
    logic [20:0]    sum;
    logic [20:0]    nn_calc;
    logic [20:0]    rr_calc;
    logic           cfg_wr;

    logic [MW-1:0]  fact_mem [DEPTH];
    logic [MW-1:0]  inv_mem  [DEPTH];
    logic [MW-1:0]  fact_rd_reg;
    logic [MW-1:0]  inv_rd_reg;
    logic [AW-1:0]  fact_addr;
    logic [AW-1:0]  inv_addr;
    logic           fact_we;
    logic           inv_we;

    // Shared modular multiplier.
    bmpt_modmul u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (mul_go_reg),
        .op_a    (mul_a_reg),
        .op_b    (mul_b_reg),
        .done    (mul_done),
        .product (mul_res)
    );

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == bmpt_pkg::REG_TABLE_TOP);
    assign prdata = (paddr[2] == bmpt_pkg::REG_TABLE_TOP) ? {16'd0, table_top_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_top_reg <= 16'hFFFF;
        end
        else if (cfg_wr)
        begin
            table_top_reg <= pwdata[15:0];
        end
    end

    // Build top clamped to at least one and at most the last table index, MAX_INDEX.
    always_comb
    begin
        if (table_top_reg == 16'd0)
        begin
            top_clamp = 16'd1;
        end
        else if (32'(table_top_reg) > 32'(MAX_INDEX))
        begin
            top_clamp = 16'(MAX_INDEX);
        end
        else
        begin
            top_clamp = table_top_reg;
        end
    end

    // Query indexes: stars and bars maps to C(items+boxes-1, items).
    assign sum     = {1'b0, req_reg.n_value} + {1'b0, req_reg.r_value};
    assign nn_calc = (req_reg.req_type == bmpt_pkg::REQ_STARS) ? sum - 21'd1
                                                               : {1'b0, req_reg.n_value};
    assign rr_calc = (req_reg.req_type == bmpt_pkg::REQ_STARS) ? {1'b0, req_reg.n_value}
                                                               : {1'b0, req_reg.r_value};

    // Table memories.
    assign fact_we   = (state_reg == S_B_FACT);
    assign inv_we    = (state_reg == S_B_INV);
    assign fact_addr = fact_we ? AW'(i_reg) : AW'(nn_reg);
    assign inv_addr  = inv_we ? AW'(i_reg)
                     : (state_reg == S_Q_RD) ? AW'(nn_reg - rr_reg) : AW'(rr_reg);

    always_ff @(posedge clk)
    begin
        if (fact_we)
        begin
            fact_mem[fact_addr] <= run_reg;
        end
        fact_rd_reg <= fact_mem[fact_addr];
    end

    always_ff @(posedge clk)
    begin
        if (inv_we)
        begin
            inv_mem[inv_addr] <= acc_reg;
        end
        inv_rd_reg <= inv_mem[inv_addr];
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Sequencer for builds and queries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ready_reg     <= 1'b0;
            built_top_reg <= 16'd0;
            out_valid_reg <= 1'b0;
            mul_go_reg    <= 1'b0;
            top_reg       <= 16'd0;
            i_reg         <= 16'd0;
            bit_reg       <= 5'd0;
            run_reg       <= '0;
            acc_reg       <= '0;
            req_reg       <= '0;
            nn_reg        <= '0;
            rr_reg        <= '0;
            value_reg     <= '0;
            status_reg    <= bmpt_pkg::ST_OK;
            out_reg       <= '0;
            mul_a_reg     <= '0;
            mul_b_reg     <= '0;
        end
        else
        begin
            // The output register fills from S_DONE and empties on a taken beat.
            if ((state_reg == S_DONE) && (!out_valid_reg || rsp_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    mul_go_reg <= 1'b0;
                    if (req_valid)
                    begin
                        req_reg <= req;
                        if (req.req_type == bmpt_pkg::REQ_BUILD)
                        begin
                            top_reg   <= top_clamp;
                            i_reg     <= 16'd0;
                            run_reg   <= MW'(1);
                            state_reg <= S_B_FACT;
                        end
                        else
                        begin
                            state_reg <= S_CHECK;
                        end
                    end
                end
                // Screen the query before any table access.
                S_CHECK:
                begin
                    mul_go_reg <= 1'b0;
                    nn_reg     <= nn_calc;
                    rr_reg     <= rr_calc;
                    value_reg  <= '0;
                    if (!ready_reg)
                    begin
                        status_reg <= bmpt_pkg::ST_NOT_BUILT;
                        state_reg  <= S_DONE;
                    end
                    else if ((req_reg.req_type == bmpt_pkg::REQ_STARS) && (sum == 21'd0))
                    begin
                        status_reg <= bmpt_pkg::ST_OK;
                        state_reg  <= S_DONE;
                    end
                    else if (rr_calc > nn_calc)
                    begin
                        status_reg <= bmpt_pkg::ST_OK;
                        state_reg  <= S_DONE;
                    end
                    else if (nn_calc > {5'd0, built_top_reg})
                    begin
                        status_reg <= bmpt_pkg::ST_RANGE;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        status_reg <= bmpt_pkg::ST_OK;
                        state_reg  <= S_Q_RD;
                    end
                end
                S_Q_RD:
                begin
                    mul_go_reg <= 1'b0;
                    state_reg  <= S_Q_MUL1;
                end
                // n! times the inverse of (n-r)!.
                S_Q_MUL1:
                begin
                    mul_go_reg <= 1'b1;
                    mul_a_reg  <= fact_rd_reg;
                    mul_b_reg  <= inv_rd_reg;
                    state_reg  <= S_Q_WAIT1;
                end
                S_Q_WAIT1:
                begin
                    mul_go_reg <= mul_done && (req_reg.req_type != bmpt_pkg::REQ_NPR);
                    if (mul_done)
                    begin
                        if (req_reg.req_type == bmpt_pkg::REQ_NPR)
                        begin
                            value_reg <= mul_res;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            mul_a_reg  <= mul_res;
                            mul_b_reg  <= inv_rd_reg;
                            state_reg  <= S_Q_WAIT2;
                        end
                    end
                end
                S_Q_WAIT2:
                begin
                    mul_go_reg <= 1'b0;
                    if (mul_done)
                    begin
                        value_reg <= mul_res;
                        state_reg <= S_DONE;
                    end
                end
                // Factorial walk upward; the running product is written here.
                S_B_FACT:
                begin
                    mul_go_reg <= (i_reg != 16'd0) && (i_reg != top_reg);
                    if (i_reg == 16'd0)
                    begin
                        i_reg <= 16'd1;
                    end
                    else if (i_reg == top_reg)
                    begin
                        acc_reg   <= MW'(1);
                        bit_reg   <= 5'd0;
                        state_reg <= S_P_BIT;
                    end
                    else
                    begin
                        mul_a_reg  <= run_reg;
                        mul_b_reg  <= MW'(i_reg + 16'd1);
                        i_reg      <= i_reg + 16'd1;
                        state_reg  <= S_B_FWAIT;
                    end
                end
                S_B_FWAIT:
                begin
                    mul_go_reg <= 1'b0;
                    if (mul_done)
                    begin
                        run_reg   <= mul_res;
                        state_reg <= S_B_FACT;
                    end
                end
                // Square and multiply over the exponent bits, low bit first.
                S_P_BIT:
                begin
                    mul_go_reg <= bmpt_pkg::INV_EXP[bit_reg];
                    if (bmpt_pkg::INV_EXP[bit_reg])
                    begin
                        mul_a_reg  <= acc_reg;
                        mul_b_reg  <= run_reg;
                        state_reg  <= S_P_AWAIT;
                    end
                    else
                    begin
                        state_reg <= S_P_SQ;
                    end
                end
                S_P_AWAIT:
                begin
                    mul_go_reg <= 1'b0;
                    if (mul_done)
                    begin
                        acc_reg   <= mul_res;
                        state_reg <= S_P_SQ;
                    end
                end
                S_P_SQ:
                begin
                    mul_go_reg <= 1'b1;
                    mul_a_reg  <= run_reg;
                    mul_b_reg  <= run_reg;
                    state_reg  <= S_P_SWAIT;
                end
                S_P_SWAIT:
                begin
                    mul_go_reg <= 1'b0;
                    if (mul_done)
                    begin
                        run_reg <= mul_res;
                        if (bit_reg == 5'(MW - 1))
                        begin
                            i_reg     <= top_reg;
                            state_reg <= S_B_INV;
                        end
                        else
                        begin
                            bit_reg   <= bit_reg + 5'd1;
                            state_reg <= S_P_BIT;
                        end
                    end
                end
                // Inverse walk downward; the running inverse is written here.
                S_B_INV:
                begin
                    mul_go_reg <= (i_reg != 16'd0);
                    if (i_reg == 16'd0)
                    begin
                        built_top_reg <= top_reg;
                        ready_reg     <= 1'b1;
                        value_reg     <= '0;
                        status_reg    <= bmpt_pkg::ST_OK;
                        state_reg     <= S_DONE;
                    end
                    else
                    begin
                        mul_a_reg  <= acc_reg;
                        mul_b_reg  <= MW'(i_reg);
                        i_reg      <= i_reg - 16'd1;
                        state_reg  <= S_I_WAIT;
                    end
                end
                S_I_WAIT:
                begin
                    mul_go_reg <= 1'b0;
                    if (mul_done)
                    begin
                        acc_reg   <= mul_res;
                        state_reg <= S_B_INV;
                    end
                end
                // Hand the result to the output register once it is free.
                S_DONE:
                begin
                    mul_go_reg <= 1'b0;
                    if (!out_valid_reg || rsp_ready)
                    begin
                        out_reg.result_value <= value_reg;
                        out_reg.status       <= status_reg;
                        state_reg            <= S_IDLE;
                    end
                end
                default:
                begin
                    mul_go_reg <= 1'b0;
                    state_reg  <= S_IDLE;
                end
            endcase
        end
    end

    // A multiplier result only arrives while the sequencer waits for one.
    a_mul_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_Q_WAIT1 || state_reg == S_Q_WAIT2 ||
                      state_reg == S_B_FWAIT || state_reg == S_P_AWAIT ||
                      state_reg == S_P_SWAIT || state_reg == S_I_WAIT))
        else $error("multiplier result outside a wait state");

    // A finished build always covers at least indexes zero and one.
    a_built_top: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (built_top_reg != 16'd0))
        else $error("tables marked built with top zero");

    // Every answer is a reduced residue.
    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.result_value < bmpt_pkg::PRIME))
        else $error("result not reduced modulo the prime");

endmodule

`default_nettype wire

// ----- verif/binomial_mod_prime_tables_tb.sv -----
// ----------------------------------------------------------------------------
// binomial_mod_prime_tables_tb
// Self-checking bench for the factorial-table block. Requests are driven
// from a queue with random gaps, responses are taken with random stalls, and
// each response beat is compared with a result predicted in the bench from
// its own copy of the factorial tables, across several table sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module binomial_mod_prime_tables_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TOP_LIMIT      = 65535;
    localparam int          WATCHDOG_LIMIT = 4000000;
    localparam logic [2:0]  TABLE_TOP_ADDR = 3'(4 * bmpt_pkg::REG_TABLE_TOP);
    localparam longint unsigned MODULUS    = 1000000007;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    bmpt_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_ready;
    bmpt_pkg::rsp_t rsp;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [2:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    binomial_mod_prime_tables dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Bench copy of the block state.
    int unsigned fact_tbl [0:TOP_LIMIT];
    int unsigned inv_fact_tbl [0:TOP_LIMIT];
    bit          tbl_built;
    int unsigned tbl_top_built;
    int unsigned top_shadow;

    bmpt_pkg::req_t pending_reqs [$];
    bmpt_pkg::rsp_t expected_rsps [$];

    int  mismatches;
    int  req_beats;
    int  rsp_beats;
    int  builds_seen;
    int  status_count [0:3];
    int  req_gap;
    int  rsp_gap;
    int  idle_cycles;
    bit  quiet;
    logic req_fire;

    // Clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned mul_p(int unsigned a, int unsigned b);
        longint unsigned prod;
        prod = longint'(a) * longint'(b);
        return int'(prod % MODULUS);
    endfunction

    function automatic int unsigned pow_p(int unsigned base, int unsigned power);
        int unsigned acc;
        acc = 1;
        while (power != 0)
        begin
            if (power[0])
                acc = mul_p(acc, base);
            base = mul_p(base, base);
            power = power >> 1;
        end
        return acc;
    endfunction

    // Fill both tables up to the configured top, as a build request does.
    function automatic void build_tables();
        int unsigned top;
        top = (top_shadow < 1) ? 1 : top_shadow;
        fact_tbl[0] = 1;
        fact_tbl[1] = 1;
        for (int unsigned i = 2; i <= top; i++)
            fact_tbl[i] = mul_p(fact_tbl[i-1], i);
        inv_fact_tbl[top] = pow_p(fact_tbl[top], 1000000005);
        for (int unsigned i = top; i > 0; i--)
            inv_fact_tbl[i-1] = mul_p(inv_fact_tbl[i], i);
        tbl_top_built = top;
        tbl_built = 1'b1;
    endfunction

    // nCr when with_r is set, else nPr; guards on r > n and on the table top.
    function automatic bmpt_pkg::rsp_t choose_value(int unsigned n, int unsigned r,
                                                    bit with_r);
        bmpt_pkg::rsp_t res;
        int unsigned v;
        res = '0;
        res.status = bmpt_pkg::ST_OK;
        if (r > n)
            return res;
        if (n > tbl_top_built)
        begin
            res.status = bmpt_pkg::ST_RANGE;
            return res;
        end
        v = mul_p(fact_tbl[n], inv_fact_tbl[n-r]);
        if (with_r)
            v = mul_p(v, inv_fact_tbl[r]);
        res.result_value = v[29:0];
        return res;
    endfunction

    // Expected response beat for one request; a build updates the tables.
    function automatic bmpt_pkg::rsp_t predict_binomial(bmpt_pkg::req_t item);
        bmpt_pkg::rsp_t res;
        int unsigned sum;
        res = '0;
        res.status = bmpt_pkg::ST_OK;
        if (item.req_type == bmpt_pkg::REQ_BUILD)
            build_tables();
        else if (!tbl_built)
            res.status = bmpt_pkg::ST_NOT_BUILT;
        else if (item.req_type == bmpt_pkg::REQ_NCR)
            res = choose_value(item.n_value, item.r_value, 1'b1);
        else if (item.req_type == bmpt_pkg::REQ_NPR)
            res = choose_value(item.n_value, item.r_value, 1'b0);
        else
        begin
            sum = item.n_value + item.r_value;
            if (sum != 0)
                res = choose_value(sum - 1, item.n_value, 1'b1);
        end
        return res;
    endfunction

    function automatic bmpt_pkg::req_t make_req(logic [1:0] kind, int unsigned n,
                                                int unsigned r);
        bmpt_pkg::req_t item;
        item.req_type = kind;
        item.n_value = n[19:0];
        item.r_value = r[19:0];
        return item;
    endfunction

    // A query that lands inside the built table.
    function automatic bmpt_pkg::req_t inside_query(int unsigned top);
        int unsigned kind;
        int unsigned n;
        kind = $urandom_range(1, 3);
        n = $urandom_range(0, top);
        if (kind == 3)
            return make_req(bmpt_pkg::REQ_STARS, n, $urandom_range(0, top + 1 - n));
        if ($urandom_range(0, 9) == 0)
            return make_req(kind[1:0], n, $urandom_range(n, n + 40));
        return make_req(kind[1:0], n, $urandom_range(0, n));
    endfunction

    // Mostly well-formed queries, some builds, some out-of-range and noise.
    function automatic bmpt_pkg::req_t random_req(int unsigned top);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            return make_req(bmpt_pkg::REQ_BUILD, $urandom, $urandom);
        if (pick < 80)
            return inside_query(top);
        if (pick < 90)
            return make_req(2'($urandom_range(1, 3)),
                            $urandom_range(top + 1, top + 100), $urandom_range(0, 50));
        return make_req(2'($urandom), $urandom, $urandom);
    endfunction

    // Request driver: valid holds until the beat is taken.
    always @(negedge clk)
    begin
        logic nxt_valid;
        if (rst_n && (!req_valid || req_fire))
        begin
            nxt_valid = 1'b0;
            if (req_gap > 0)
                req_gap--;
            else if (pending_reqs.size() != 0)
            begin
                req <= pending_reqs.pop_front();
                nxt_valid = 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                    req_gap = $urandom_range(1, 19);
            end
            req_valid <= nxt_valid;
        end
    end

    // Response stalls.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_gap > 0)
            begin
                rsp_gap--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0)
                    rsp_gap = $urandom_range(1, 19);
            end
        end
    end

    // Monitor: predict on each request beat, check each response beat.
    always @(posedge clk)
    begin
        bmpt_pkg::rsp_t exp_rsp;
        req_fire <= req_valid && req_ready;
        if (rst_n)
        begin
            idle_cycles++;
            if (rsp_valid && rsp_ready)
            begin
                idle_cycles = 0;
                rsp_beats++;
                if (expected_rsps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected response beat value=%0d status=%0d",
                                 rsp.result_value, rsp.status);
                end
                else
                begin
                    exp_rsp = expected_rsps.pop_front();
                    status_count[rsp.status]++;
                    if (rsp.result_value !== exp_rsp.result_value ||
                        rsp.status !== exp_rsp.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: beat %0d expected value=%0d status=%0d, ",
                                      "got value=%0d status=%0d"},
                                     rsp_beats, exp_rsp.result_value, exp_rsp.status,
                                     rsp.result_value, rsp.status);
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                idle_cycles = 0;
                req_beats++;
                if (req.req_type == bmpt_pkg::REQ_BUILD)
                    builds_seen++;
                expected_rsps.push_back(predict_binomial(req));
            end
        end
    end

    // Watchdog on cycles without any beat.
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic reg_write(logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= TABLE_TOP_ADDR;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        top_shadow = value[15:0];
    endtask

    task automatic reg_readback();
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        paddr <= TABLE_TOP_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[15:0] !== top_shadow[15:0])
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: table_top read expected %0d, got %0d",
                         top_shadow, prdata[15:0]);
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait until every queued request is answered, then let the block settle.
    task automatic drain();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_valid)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_top(int unsigned top);
        reg_write(top);
        reg_readback();
    endtask

    // Build at the given top, then a batch of random requests.
    task automatic random_phase(int unsigned top, int count);
        set_top(top);
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_BUILD, 0, 0));
        for (int i = 0; i < count; i++)
            pending_reqs.push_back(random_req(top));
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_fire = 1'b0;
        quiet = 1'b0;
        top_shadow = TOP_LIMIT;
        tbl_built = 1'b0;
        tbl_top_built = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset value of the register, then queries before any build.
        reg_readback();
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_NCR, 3, 1));
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_NPR, 0, 0));
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_STARS, 20'hFFFFF, 20'hFFFFF));
        drain();

        // Smallest table: only entries 0 and 1 exist.
        set_top(1);
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_BUILD, 20'hFFFFF, 20'hFFFFF));
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_NCR, 0, 0));
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_NCR, 1, 1));
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_NPR, 1, 0));
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_NCR, 2, 1));
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_NPR, 1, 2));
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_STARS, 0, 0));
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_STARS, 1, 0));
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_STARS, 0, 1));
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_STARS, 1, 1));
        drain();

        // Mid-size table with field extremes.
        set_top(1000);
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_BUILD, 0, 0));
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_NCR, 1000, 500));
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_NPR, 1000, 1000));
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_NCR, 1001, 3));
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_NCR, 20'hFFFFF, 20'hFFFFF));
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_NPR, 20'hFFFFF, 0));
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_STARS, 500, 501));
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_STARS, 500, 502));
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_STARS, 0, 20'hFFFFF));
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_NCR, 0, 20'hFFFFF));
        drain();

        // Random part over several table sizes.
        random_phase(2, 40);
        random_phase($urandom_range(3, 40), 60);
        random_phase($urandom_range(41, 300), 80);
        random_phase($urandom_range(3, 300), 80);
        random_phase($urandom_range(100, 2000), 60);

        // Largest table, run without idling on either side.
        quiet = 1'b1;
        set_top(TOP_LIMIT);
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_BUILD, 0, 0));
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_NCR, TOP_LIMIT, 32768));
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_NPR, TOP_LIMIT, TOP_LIMIT));
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_STARS, 32768, 32768));
        pending_reqs.push_back(make_req(bmpt_pkg::REQ_NCR, TOP_LIMIT + 1, 1));
        for (int i = 0; i < 30; i++)
            pending_reqs.push_back(random_req(TOP_LIMIT));
        drain();

        $display("Covered %0d request beats (%0d builds) and %0d response beats.",
                 req_beats, builds_seen, rsp_beats);
        $display("Statuses seen: ok %0d, beyond table %0d, not built %0d; mismatches %0d.",
                 status_count[0], status_count[1], status_count[2], mismatches);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
